FILE: rtl/pfr_pkg.sv
// Package for the parameter frame receiver.
// Holds status codes, frame byte positions and the result item type.
// No dependencies.
package pfr_pkg;

   localparam logic [1:0] StatusAccepted = 2'd0;
   localparam logic [1:0] StatusRejected = 2'd1;
   localparam logic [1:0] StatusIgnored  = 2'd2;
   localparam logic [1:0] StatusResetReq = 2'd3;

   localparam logic [3:0] PosHeader   = 4'd0;
   localparam logic [3:0] PosLength   = 4'd1;
   localparam logic [3:0] PosZero     = 4'd3;
   localparam logic [3:0] PosCheck    = 4'd4;
   localparam logic [3:0] PosIndex    = 4'd5;
   localparam logic [3:0] PosValue0   = 4'd7;
   localparam logic [3:0] PosValue1   = 4'd8;
   localparam logic [3:0] PosValue2   = 4'd9;
   localparam logic [3:0] PosValue3   = 4'd10;
   localparam logic [3:0] FrameMinLen = 4'd11;

   localparam logic [7:0] CheckByte4 = 8'h5A;
   localparam logic [7:0] ResetIndex = 8'hFF;

   localparam logic csr_header = 1'b0;
   localparam logic csr_slots  = 1'b1;

   typedef struct packed {
      logic [1:0]  status;
      logic [3:0]  slot;
      logic [31:0] value_bits;
      logic [15:0] received_bits;
      logic        all_received;
   } result_type;

endpackage

FILE: rtl/parameter_frame_receiver_core.sv
// Parameter frame receiver, top level: input register, configuration
// registers and result register around pfr_frame_engine; uses pfr_pkg.
// A frame's last byte passes the input register, then the result register.
// Throughput: one byte per cycle; the input register drains into the frame
// engine while a result waits, and only a second result stalls the input.
// Reset (synchronous, active high) clears the configuration, frame state and mask.
module parameter_frame_receiver_core import pfr_pkg::*; #(
   parameter int MAX_SLOTS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   input  logic        req_frame_end,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [3:0]  rsp_slot,
   output logic [31:0] rsp_value_bits,
   output logic [15:0] rsp_received_bits,
   output logic        rsp_all_received,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [7:0]  csr_wdata
);

   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_end_ff;
   logic [7:0] header_ff;
   logic [4:0] slots_ff;
   logic       rsp_valid_ff;
   result_type rsp_ff;
   result_type result;
   logic       advance, out_free, req_take;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && (!in_end_ff || out_free);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   pfr_frame_engine #(
      .MAX_SLOTS (MAX_SLOTS)
   ) u_engine (
      .clock        (clock),
      .reset        (reset),
      .step         (advance),
      .rx_byte      (in_byte_ff),
      .frame_end    (in_end_ff),
      .header_byte  (header_ff),
      .slots_in_use (slots_ff),
      .result       (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff <= '0;
         slots_ff  <= '0;
      end else if (csr_we) begin
         case (csr_index)
            csr_header: header_ff <= csr_wdata;
            csr_slots:  slots_ff  <= csr_wdata[4:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_rx_byte;
         in_end_ff  <= req_frame_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && in_end_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_end_ff) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_ff.status;
   assign rsp_slot          = rsp_ff.slot;
   assign rsp_value_bits    = rsp_ff.value_bits;
   assign rsp_received_bits = rsp_ff.received_bits;
   assign rsp_all_received  = rsp_ff.all_received;

endmodule

FILE: rtl/pfr_frame_engine.sv
// Frame tracking and verdict logic for the parameter frame receiver.
// Keeps the per-frame state and the received slot mask; uses pfr_pkg.
module pfr_frame_engine import pfr_pkg::*; #(
   parameter int MAX_SLOTS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        step,
   input  logic [7:0]  rx_byte,
   input  logic        frame_end,
   input  logic [7:0]  header_byte,
   input  logic [4:0]  slots_in_use,
   output result_type  result
);

   localparam int MaskW = (MAX_SLOTS > 16) ? MAX_SLOTS : 16;
   localparam logic [5:0] MaxSlots = 6'(MAX_SLOTS);

   logic [3:0]           pos_ff, pos_in;
   logic                 chk_ff, chk_in;
   logic [7:0]           idx_ff, idx_in;
   logic [31:0]          val_ff, val_in;
   logic [MAX_SLOTS-1:0] mask_ff, mask_in;
   logic [MAX_SLOTS-1:0] full_mask, sel_mask, mask_set;
   logic [5:0]           n_slots;
   logic [MaskW-1:0]     mask_wide;
   logic                 frame_ok, in_range, all_hit;

   always_comb begin
      chk_in = chk_ff;
      idx_in = idx_ff;
      val_in = val_ff;
      case (pos_ff)
         PosHeader: begin
            if (rx_byte != header_byte) chk_in = 1'b0;
         end
         PosLength: begin
            if (rx_byte != {1'b0, slots_in_use, 2'b00}) chk_in = 1'b0;
         end
         PosZero: begin
            if (rx_byte != 8'd0) chk_in = 1'b0;
         end
         PosCheck: begin
            if (rx_byte != CheckByte4) chk_in = 1'b0;
         end
         PosIndex: begin
            idx_in = rx_byte;
         end
         PosValue0, PosValue1, PosValue2, PosValue3: begin
            val_in = {rx_byte, val_ff[31:8]};
         end
         default: begin
         end
      endcase
      pos_in = (pos_ff < FrameMinLen) ? pos_ff + 4'd1 : pos_ff;
   end

   always_comb begin
      n_slots = ({1'b0, slots_in_use} > MaxSlots) ? MaxSlots : {1'b0, slots_in_use};
      for (int i = 0; i < MAX_SLOTS; i++) begin
         full_mask[i] = (6'(i) < n_slots);
         sel_mask[i]  = (idx_in == 8'(i + 1));
      end
      frame_ok = (pos_in == FrameMinLen) && chk_in;
      in_range = (idx_in != 8'd0) && (idx_in <= {2'b00, n_slots});
      mask_set = in_range ? (mask_ff | sel_mask) : mask_ff;
      all_hit  = (idx_in != ResetIndex || in_range) && (mask_set == full_mask);

      result        = '0;
      result.status = StatusRejected;
      mask_in       = mask_ff;
      if (frame_ok) begin
         if (in_range) begin
            result.status     = StatusAccepted;
            result.slot       = idx_in[3:0] - 4'd1;
            result.value_bits = val_in;
         end else if (idx_in == ResetIndex) begin
            result.status = StatusResetReq;
         end else begin
            result.status = StatusIgnored;
         end
         mask_in = all_hit ? '0 : mask_set;
         result.all_received = all_hit;
      end
      mask_wide            = MaskW'(mask_in);
      result.received_bits = mask_wide[15:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         chk_ff  <= 1'b1;
         idx_ff  <= '0;
         val_ff  <= '0;
         mask_ff <= '0;
      end else if (step) begin
         if (frame_end) begin
            pos_ff  <= '0;
            chk_ff  <= 1'b1;
            idx_ff  <= '0;
            val_ff  <= '0;
            mask_ff <= mask_in;
         end else begin
            pos_ff <= pos_in;
            chk_ff <= chk_in;
            idx_ff <= idx_in;
            val_ff <= val_in;
         end
      end
   end

endmodule

FILE: test/tb.sv
`timescale 1ns / 100ps
// Testbench for parameter_frame_receiver_core: directed frames, then random frame traffic
// under three idling patterns, each result checked against a behavioral predictor.
// Depends on pfr_pkg and the core RTL only.
module tb;
   import pfr_pkg::*;

   localparam int MaxSlots   = 16;
   localparam int CycleLimit = 400000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_rx_byte;
   logic        req_frame_end;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [1:0]  rsp_status;
   logic [3:0]  rsp_slot;
   logic [31:0] rsp_value_bits;
   logic [15:0] rsp_received_bits;
   logic        rsp_all_received;
   logic        csr_we;
   logic        csr_index;
   logic [7:0]  csr_wdata;

   parameter_frame_receiver_core #(.MAX_SLOTS(MaxSlots)) u_top (.*);

   // Predictor state and configuration copy.
   logic [7:0]  header_cfg;
   logic [4:0]  slots_cfg;
   logic [3:0]  frame_pos;
   logic        frame_ok;
   logic [7:0]  index_byte;
   logic [31:0] word_shift;
   logic [15:0] slot_mask;

   result_type  verdict_queue[$];
   logic [7:0]  frame_buf[$];

   int send_gap_pct;
   int stall_pct;
   int cycle_count;
   int mismatch_count;
   int bytes_sent;
   int frames_sent;
   int results_checked;
   int all_count;
   int status_count[4];
   result_type seen_result;
   result_type want_result;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("Timeout after %0d cycles with %0d results pending", cycle_count,
                  verdict_queue.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   task automatic track_byte(input logic [7:0] b, input logic last);
      logic [4:0]  n;
      logic [16:0] full;
      result_type  want;
      case (frame_pos)
         PosHeader: if (b != header_cfg) frame_ok = 1'b0;
         PosLength: if (b != 8'({slots_cfg, 2'b00})) frame_ok = 1'b0;
         PosZero:   if (b != 8'h00) frame_ok = 1'b0;
         PosCheck:  if (b != CheckByte4) frame_ok = 1'b0;
         PosIndex:  index_byte = b;
         PosValue0, PosValue1, PosValue2, PosValue3: word_shift = {b, word_shift[31:8]};
         default: ;
      endcase
      if (frame_pos < FrameMinLen) frame_pos = frame_pos + 4'd1;
      if (last) begin
         n = (slots_cfg > 5'(MaxSlots)) ? 5'(MaxSlots) : slots_cfg;
         full = (17'd1 << n) - 17'd1;
         want = '0;
         want.status = StatusRejected;
         if (frame_pos >= FrameMinLen && frame_ok) begin
            if (index_byte >= 8'd1 && index_byte <= {3'b000, n}) begin
               want.status = StatusAccepted;
               want.slot = 4'(index_byte - 8'd1);
               want.value_bits = word_shift;
               slot_mask = slot_mask | 16'(17'd1 << (index_byte - 8'd1));
            end else if (index_byte == ResetIndex) begin
               want.status = StatusResetReq;
            end else begin
               want.status = StatusIgnored;
            end
            if (want.status != StatusResetReq && {1'b0, slot_mask} == full) begin
               want.all_received = 1'b1;
               slot_mask = '0;
            end
         end
         want.received_bits = slot_mask;
         verdict_queue.push_back(want);
         frame_pos = '0;
         frame_ok = 1'b1;
         index_byte = '0;
         word_shift = '0;
      end
   endtask

   task automatic send_item(input logic [7:0] b, input logic last);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= b;
      req_frame_end <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      track_byte(b, last);
      bytes_sent++;
   endtask

   task automatic send_frame();
      foreach (frame_buf[i]) begin
         send_item(frame_buf[i], i == frame_buf.size() - 1);
      end
      frames_sent++;
   endtask

   task automatic make_frame(input logic [7:0] index, input logic [31:0] word);
      frame_buf = {};
      frame_buf.push_back(header_cfg);
      frame_buf.push_back(8'({slots_cfg, 2'b00}));
      frame_buf.push_back(8'($urandom));
      frame_buf.push_back(8'h00);
      frame_buf.push_back(CheckByte4);
      frame_buf.push_back(index);
      frame_buf.push_back(8'($urandom));
      frame_buf.push_back(word[7:0]);
      frame_buf.push_back(word[15:8]);
      frame_buf.push_back(word[23:16]);
      frame_buf.push_back(word[31:24]);
   endtask

   // Holds the input idle until every pending result has arrived and the core is quiet.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (verdict_queue.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic sel, input logic [7:0] data);
      csr_we <= 1'b1;
      csr_index <= sel;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      if (sel == csr_header) header_cfg = data;
      else slots_cfg = data[4:0];
      @(posedge clock);
   endtask

   task automatic pick_config();
      int pick;
      pick = $urandom_range(9);
      write_csr(csr_header, (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom));
      pick = $urandom_range(19);
      case (pick)
         0:       write_csr(csr_slots, 8'd0);
         1:       write_csr(csr_slots, 8'd16);
         2:       write_csr(csr_slots, 8'd31);
         3, 4:    write_csr(csr_slots, 8'($urandom_range(30, 17)));
         5, 6, 7: write_csr(csr_slots, 8'($urandom_range(3, 1)));
         default: write_csr(csr_slots, 8'($urandom_range(15, 1)));
      endcase
   endtask

   task automatic test_reset_defaults();
      make_frame(8'd0, 32'h1234_5678);
      send_frame();
      make_frame(ResetIndex, 32'($urandom));
      send_frame();
      make_frame(8'd1, 32'($urandom));
      send_frame();
      settle();
   endtask

   task automatic test_frame_checks();
      write_csr(csr_header, 8'hFF);
      write_csr(csr_slots, 8'd3);
      make_frame(8'd1, 32'($urandom));
      frame_buf[0] = 8'hFE;
      send_frame();
      make_frame(8'd1, 32'($urandom));
      frame_buf[1] = 8'd4;
      send_frame();
      make_frame(8'd1, 32'($urandom));
      frame_buf[3] = 8'h80;
      send_frame();
      make_frame(8'd1, 32'($urandom));
      frame_buf[4] = 8'hA5;
      send_frame();
      make_frame(8'd1, 32'($urandom));
      void'(frame_buf.pop_back());
      send_frame();
      frame_buf = {8'hFF};
      send_frame();
      make_frame(8'd2, 32'hFFFF_FFFF);
      repeat (3) frame_buf.push_back(8'($urandom));
      send_frame();
      make_frame(8'd0, 32'($urandom));
      send_frame();
      make_frame(8'd4, 32'($urandom));
      send_frame();
      make_frame(ResetIndex, 32'($urandom));
      send_frame();
      settle();
   endtask

   task automatic test_slot_fill();
      write_csr(csr_header, 8'h00);
      make_frame(8'd1, 32'h0000_0000);
      send_frame();
      make_frame(8'd3, 32'h8000_0001);
      send_frame();
      make_frame(8'd2, 32'($urandom));
      send_frame();
      make_frame(8'd1, 32'($urandom));
      send_frame();
      settle();
   endtask

   task automatic test_slot_clamp();
      write_csr(csr_slots, 8'd31);
      make_frame(8'd16, 32'($urandom));
      send_frame();
      make_frame(8'd17, 32'($urandom));
      send_frame();
      settle();
   endtask

   task automatic test_random_traffic(input int gap_pct, input int stall_level, input int budget);
      int          stop_at;
      int          kind;
      int          n;
      logic [7:0]  index;
      send_gap_pct = gap_pct;
      stall_pct = stall_level;
      pick_config();
      stop_at = bytes_sent + budget;
      while (bytes_sent < stop_at) begin
         n = (slots_cfg > 5'(MaxSlots)) ? MaxSlots : int'(slots_cfg);
         kind = $urandom_range(9);
         if (kind < 7 && n > 0) index = 8'($urandom_range(n, 1));
         else if (kind == 7) index = 8'd0;
         else if (kind == 8) index = ResetIndex;
         else index = 8'($urandom);
         make_frame(index, 32'($urandom));
         kind = $urandom_range(99);
         if (kind < 75) begin
            if ($urandom_range(4) == 0) begin
               repeat ($urandom_range(5, 1)) frame_buf.push_back(8'($urandom));
            end
         end else if (kind < 88) begin
            case ($urandom_range(4))
               0: frame_buf[0] = frame_buf[0] ^ 8'($urandom_range(255, 1));
               1: frame_buf[1] = frame_buf[1] ^ 8'($urandom_range(255, 1));
               2: frame_buf[3] = frame_buf[3] ^ 8'($urandom_range(255, 1));
               3: frame_buf[4] = frame_buf[4] ^ 8'($urandom_range(255, 1));
               default: begin
                  repeat ($urandom_range(10, 1)) void'(frame_buf.pop_back());
               end
            endcase
         end else begin
            frame_buf = {};
            repeat ($urandom_range(16, 1)) frame_buf.push_back(8'($urandom));
         end
         send_frame();
         if ($urandom_range(39) == 0) begin
            settle();
         end
         if ($urandom_range(29) == 0) begin
            settle();
            pick_config();
         end
      end
      settle();
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         seen_result.status = rsp_status;
         seen_result.slot = rsp_slot;
         seen_result.value_bits = rsp_value_bits;
         seen_result.received_bits = rsp_received_bits;
         seen_result.all_received = rsp_all_received;
         if (verdict_queue.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("Unexpected result at cycle %0d: %p", cycle_count, seen_result);
            end
         end else begin
            want_result = verdict_queue.pop_front();
            results_checked++;
            status_count[want_result.status]++;
            if (want_result.all_received) all_count++;
            if (seen_result.status !== want_result.status
                || seen_result.slot !== want_result.slot
                || seen_result.value_bits !== want_result.value_bits
                || seen_result.received_bits !== want_result.received_bits
                || seen_result.all_received !== want_result.all_received) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("Result mismatch at cycle %0d", cycle_count);
                  $display("  expected %p", want_result);
                  $display("  actual   %p", seen_result);
               end
            end
         end
      end
   end

   initial begin
      clock = 1'b0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_rx_byte <= '0;
      req_frame_end <= 1'b0;
      rsp_stall <= 1'b0;
      csr_we <= 1'b0;
      csr_index <= csr_header;
      csr_wdata <= '0;
      cycle_count = 0;
      header_cfg = '0;
      slots_cfg = '0;
      frame_pos = '0;
      frame_ok = 1'b1;
      index_byte = '0;
      word_shift = '0;
      slot_mask = '0;
      send_gap_pct = 6;
      stall_pct = 73;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_frame_checks();
      test_slot_fill();
      test_slot_clamp();
      test_random_traffic(6, 73, 583);
      test_random_traffic(73, 6, 583);
      test_random_traffic(0, 0, 583);

      settle();
      repeat (8) @(posedge clock);
      $display("Sent %0d bytes in %0d frames; checked %0d results.", bytes_sent, frames_sent,
               results_checked);
      $display("Accepted %0d, rejected %0d, ignored %0d, reset requests %0d, complete sets %0d.",
               status_count[0], status_count[1], status_count[2], status_count[3], all_count);
      if (mismatch_count == 0 && verdict_queue.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
